// ===== rtl/core/wcfb_pkg.sv =====
// Shared types, constants and the CRC byte update for the wheel command frame builder.
package wcfb_pkg;

   localparam int FRAME_BYTES = 28;
   localparam int POS_W = $clog2(FRAME_BYTES);
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [POS_W-1:0] FIRST_POS = POS_W'(0);
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);
   localparam logic [POS_W-1:0] CRC_FIRST_POS = POS_W'(1);
   localparam logic [POS_W-1:0] CRC_LAST_POS = POS_W'(23);

   localparam logic [7:0] HEADER_BYTE = 8'hAA;
   localparam logic [7:0] DATA_LEN = 8'd22;
   localparam logic [15:0] CRC_POLY = 16'h8005;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   localparam logic CSR_IDX_GROUP = 1'b0;
   localparam logic CSR_IDX_ROBOT = 1'b1;

   typedef struct packed {
      logic signed [15:0] left_speed;
      logic signed [15:0] right_speed;
      logic [15:0]        mode_word;
      logic [7:0]         command_code;
      logic [31:0]        odo_x_bits;
      logic [31:0]        odo_y_bits;
      logic [31:0]        odo_heading_bits;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]       frame_byte;
      logic [POS_W-1:0] byte_position;
      logic             frame_last;
   } rsp_payload_type;

   typedef struct packed {
      logic       clear;
      logic       update;
      logic [7:0] data;
   } crc_ctrl_type;

   function automatic logic [15:0] crc16_byte_update(input logic [15:0] crc_value,
                                                     input logic [7:0] data_byte);
      logic [15:0] acc;
      acc = crc_value ^ {data_byte, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (acc[15]) begin
            acc = {acc[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            acc = {acc[14:0], 1'b0};
         end
      end
      return acc;
   endfunction

endpackage

// ===== rtl/core/wcfb_csr.sv =====
// Configuration registers for the group and robot numbers behind an APB-style port.
module wcfb_csr
   import wcfb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [7:0]            group_id,
   output logic [15:0]           robot_id
);

   logic [7:0]  group_id_ff;
   logic [7:0]  group_id_in;
   logic [15:0] robot_id_ff;
   logic [15:0] robot_id_in;
   logic        write_en;

   assign csr_pready = 1'b1;
   assign write_en = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      group_id_in = group_id_ff;
      robot_id_in = robot_id_ff;
      if (write_en) begin
         case (csr_paddr[2])
            CSR_IDX_GROUP: group_id_in = csr_pwdata[7:0];
            CSR_IDX_ROBOT: robot_id_in = csr_pwdata[15:0];
            default: begin
               group_id_in = group_id_ff;
               robot_id_in = robot_id_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_id_ff <= '0;
         robot_id_ff <= '0;
      end else begin
         group_id_ff <= group_id_in;
         robot_id_ff <= robot_id_in;
      end
   end

   always_comb begin
      case (csr_paddr[2])
         CSR_IDX_GROUP: csr_prdata = {{(CSR_DATA_W-8){1'b0}}, group_id_ff};
         CSR_IDX_ROBOT: csr_prdata = {{(CSR_DATA_W-16){1'b0}}, robot_id_ff};
         default:       csr_prdata = '0;
      endcase
   end

   assign group_id = group_id_ff;
   assign robot_id = robot_id_ff;

endmodule

// ===== rtl/core/wcfb_crc.sv =====
// Running CRC-16 register, advanced by one frame byte per cycle while its update input is set.
module wcfb_crc
   import wcfb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  crc_ctrl_type crc_ctrl,
   output logic [15:0]  crc_value
);

   logic [15:0] crc_ff;
   logic [15:0] crc_in;

   always_comb begin
      crc_in = crc_ff;
      if (crc_ctrl.clear) begin
         crc_in = CRC_INIT;
      end else if (crc_ctrl.update) begin
         crc_in = crc16_byte_update(crc_ff, crc_ctrl.data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CRC_INIT;
      end else begin
         crc_ff <= crc_in;
      end
   end

   assign crc_value = crc_ff;

endmodule

// ===== rtl/core/wcfb_serializer.sv =====
// Command holding register, byte counter, frame byte selection and output register.
module wcfb_serializer
   import wcfb_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload,
   input  logic [7:0]      group_id,
   input  logic [15:0]     robot_id,
   input  logic [15:0]     crc_value,
   output crc_ctrl_type    crc_ctrl
);

   req_payload_type             item_ff;
   logic                        item_valid_ff;
   logic                        item_valid_in;
   logic [POS_W-1:0]            pos_ff;
   logic [POS_W-1:0]            pos_in;
   rsp_payload_type             rsp_ff;
   rsp_payload_type             rsp_in;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic                        advance;
   logic                        at_last;
   logic                        req_take;
   logic [FRAME_BYTES-1:0][7:0] frame;

   assign advance = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign at_last = (pos_ff == LAST_POS);
   assign req_ready = !item_valid_ff || (advance && at_last);
   assign req_take = req_valid && req_ready;

   always_comb begin
      frame = '0;
      frame[0] = HEADER_BYTE;
      frame[1] = DATA_LEN;
      frame[2] = group_id;
      frame[3] = item_ff.command_code;
      frame[5:4] = robot_id;
      frame[7:6] = item_ff.mode_word;
      frame[9:8] = item_ff.left_speed;
      frame[11:10] = item_ff.right_speed;
      frame[15:12] = item_ff.odo_x_bits;
      frame[19:16] = item_ff.odo_y_bits;
      frame[23:20] = item_ff.odo_heading_bits;
      frame[24] = crc_value[15:8];
      frame[25] = crc_value[7:0];
   end

   assign crc_ctrl.clear = advance && (pos_ff == FIRST_POS);
   assign crc_ctrl.update = advance && (pos_ff inside {[CRC_FIRST_POS:CRC_LAST_POS]});
   assign crc_ctrl.data = frame[pos_ff];

   always_comb begin
      item_valid_in = item_valid_ff;
      pos_in = pos_ff;
      if (advance) begin
         pos_in = at_last ? FIRST_POS : pos_ff + POS_W'(1);
         if (at_last) begin
            item_valid_in = 1'b0;
         end
      end
      if (req_take) begin
         item_valid_in = 1'b1;
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_in.frame_byte = frame[pos_ff];
         rsp_in.byte_position = pos_ff;
         rsp_in.frame_last = at_last;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         pos_ff <= FIRST_POS;
         rsp_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         pos_ff <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= req_payload;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef NO_ASSERTIONS
   a_last_flag_matches_position: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.frame_last == (rsp_ff.byte_position == LAST_POS)))
      else $error("frame_last disagrees with byte_position");

   a_header_first: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.byte_position == FIRST_POS) |-> rsp_ff.frame_byte == HEADER_BYTE)
      else $error("frame does not open with the header byte");

   a_position_steps: assert property (@(posedge clock) disable iff (reset)
      (advance && !at_last) |=> pos_ff == $past(pos_ff) + POS_W'(1))
      else $error("byte position skipped or repeated");

   a_crc_starts_fresh: assert property (@(posedge clock) disable iff (reset)
      crc_ctrl.clear |=> crc_value == CRC_INIT)
      else $error("CRC not at its initial value at the start of a frame");
`endif

endmodule

// ===== rtl/core/wheel_command_frame_builder.sv =====
// The header byte of a command passes through the command holding register and then the output register to rsp.
// Frames leave at one frame byte per cycle while rsp_ready does not stall the output, 28 bytes per command.
// The next command beat is taken in the cycle the last byte of the frame enters the output register.
// The CRC is advanced by one byte per cycle as bytes 1 to 23 leave the holding register.
// Reset is synchronous and active high; it empties the block and clears both identifiers to zero.
module wheel_command_frame_builder
   import wcfb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_payload_type       rsp_payload,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [7:0]   group_id;
   logic [15:0]  robot_id;
   logic [15:0]  crc_value;
   crc_ctrl_type crc_ctrl;

   wcfb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .group_id    (group_id),
      .robot_id    (robot_id)
   );

   wcfb_crc u_crc (
      .clock     (clock),
      .reset     (reset),
      .crc_ctrl  (crc_ctrl),
      .crc_value (crc_value)
   );

   wcfb_serializer u_serializer (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .group_id    (group_id),
      .robot_id    (robot_id),
      .crc_value   (crc_value),
      .crc_ctrl    (crc_ctrl)
   );

endmodule

// ===== test/wheel_command_frame_builder_test.sv =====
// Self-checking testbench for the wheel command frame builder, with a frame predictor and random stalls.
module wheel_command_frame_builder_test;
   import wcfb_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int RANDOM_PHASES = 5;
   localparam int COMMANDS_PER_PHASE = 20;
   localparam int MAX_PRINTED = 100;

   localparam logic [7:0] CMD_WHEELS = 8'd1;
   localparam logic [7:0] CMD_LED = 8'd2;
   localparam logic [7:0] CMD_WHEELS_ODOMETRY = 8'd3;
   localparam logic [15:0] MODE_OFF = 16'd0;
   localparam logic [15:0] MODE_ON = 16'd3;
   localparam logic [15:0] MODE_ODO_PRESET = 16'd4;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   req_payload_type command_queue[$];
   rsp_payload_type expected_bytes[$];
   logic [7:0] group_setting = 8'h00;
   logic [15:0] robot_setting = 16'h0000;
   logic idling_on = 1'b1;
   int commands_issued = 0;
   int commands_accepted = 0;
   int mismatch_count = 0;
   int result_beats = 0;
   int cycle_count = 0;
   int send_gap = 0;
   int stall_left = 0;

   wheel_command_frame_builder i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #4 clock = ~clock;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < MAX_PRINTED) begin
         $display("mismatch: %s got 0x%0h expected 0x%0h at result beat %0d",
                  what, got, want, result_beats);
      end
      mismatch_count++;
   endtask

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
         return $urandom_range(1, 2);
      end else if (roll < 95) begin
         return $urandom_range(3, 8);
      end else begin
         return $urandom_range(20, 60);
      end
   endfunction

   function automatic logic [15:0] crc_advance(input logic [15:0] crc, input logic [7:0] octet);
      logic feedback;
      for (int k = 7; k >= 0; k--) begin
         feedback = crc[15] ^ octet[k];
         crc = {crc[14:0], 1'b0};
         if (feedback) begin
            crc = crc ^ CRC_POLY;
         end
      end
      return crc;
   endfunction

   function automatic void predict_frame(input req_payload_type cmd);
      logic [7:0] frame [FRAME_BYTES];
      logic [15:0] crc;
      rsp_payload_type beat;
      frame[0] = HEADER_BYTE;
      frame[1] = DATA_LEN;
      frame[2] = group_setting;
      frame[3] = cmd.command_code;
      for (int i = 0; i < 2; i++) begin
         frame[4 + i] = robot_setting[8*i +: 8];
         frame[6 + i] = cmd.mode_word[8*i +: 8];
         frame[8 + i] = cmd.left_speed[8*i +: 8];
         frame[10 + i] = cmd.right_speed[8*i +: 8];
      end
      for (int i = 0; i < 4; i++) begin
         frame[12 + i] = cmd.odo_x_bits[8*i +: 8];
         frame[16 + i] = cmd.odo_y_bits[8*i +: 8];
         frame[20 + i] = cmd.odo_heading_bits[8*i +: 8];
      end
      crc = CRC_INIT;
      for (int i = 1; i <= 23; i++) begin
         crc = crc_advance(crc, frame[i]);
      end
      frame[24] = crc[15:8];
      frame[25] = crc[7:0];
      frame[26] = 8'h00;
      frame[27] = 8'h00;
      for (int i = 0; i < FRAME_BYTES; i++) begin
         beat.frame_byte = frame[i];
         beat.byte_position = POS_W'(i);
         beat.frame_last = (i == FRAME_BYTES - 1);
         expected_bytes.push_back(beat);
      end
   endfunction

   function automatic req_payload_type make_command(input logic [15:0] left,
                                                    input logic [15:0] right,
                                                    input logic [15:0] mode,
                                                    input logic [7:0] code,
                                                    input logic [31:0] x,
                                                    input logic [31:0] y,
                                                    input logic [31:0] heading);
      req_payload_type cmd;
      cmd.left_speed = left;
      cmd.right_speed = right;
      cmd.mode_word = mode;
      cmd.command_code = code;
      cmd.odo_x_bits = x;
      cmd.odo_y_bits = y;
      cmd.odo_heading_bits = heading;
      return cmd;
   endfunction

   function automatic req_payload_type random_command();
      req_payload_type cmd;
      cmd = make_command(16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                         $urandom, $urandom, $urandom);
      if ($urandom_range(0, 9) < 7) begin
         case ($urandom_range(0, 2))
            0: cmd.command_code = CMD_WHEELS;
            1: cmd.command_code = CMD_LED;
            default: cmd.command_code = CMD_WHEELS_ODOMETRY;
         endcase
         case ($urandom_range(0, 2))
            0: cmd.mode_word = MODE_OFF;
            1: cmd.mode_word = MODE_ON;
            default: cmd.mode_word = MODE_ODO_PRESET;
         endcase
      end
      if ($urandom_range(0, 9) == 0) begin
         cmd.left_speed = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
         cmd.right_speed = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      end
      return cmd;
   endfunction

   task automatic queue_command(input req_payload_type cmd);
      command_queue.push_back(cmd);
      commands_issued++;
   endtask

   task automatic write_register(input logic index, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (index == CSR_IDX_GROUP) begin
         group_setting = value[7:0];
      end else begin
         robot_setting = value[15:0];
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic read_register(input logic index);
      logic [CSR_DATA_W-1:0] want;
      want = (index == CSR_IDX_GROUP) ? CSR_DATA_W'(group_setting) : CSR_DATA_W'(robot_setting);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= {index, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== want) begin
         report_mismatch("register read", csr_prdata, want);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic wait_until_drained();
      do begin
         @(posedge clock);
      end while (commands_accepted != commands_issued || expected_bytes.size() != 0);
   endtask

   task automatic set_identifiers(input logic [CSR_DATA_W-1:0] group_value,
                                  input logic [CSR_DATA_W-1:0] robot_value);
      write_register(CSR_IDX_GROUP, group_value);
      write_register(CSR_IDX_ROBOT, robot_value);
      read_register(CSR_IDX_GROUP);
      read_register(CSR_IDX_ROBOT);
   endtask

   always @(posedge clock) begin : drive_commands
      logic next_valid;
      req_payload_type next_payload;
      if (reset) begin
         req_valid <= 1'b0;
         req_payload <= '0;
         send_gap = 0;
      end else begin
         next_valid = req_valid;
         next_payload = req_payload;
         if (req_valid && req_ready) begin
            predict_frame(req_payload);
            commands_accepted++;
            next_valid = 1'b0;
            send_gap = (idling_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
         end
         if (!next_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (command_queue.size() != 0) begin
               next_payload = command_queue.pop_front();
               next_valid = 1'b1;
            end
         end
         req_valid <= next_valid;
         req_payload <= next_payload;
      end
   end

   always @(posedge clock) begin : accept_results
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         stall_left = pick_gap() - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_results
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bytes.size() == 0) begin
            report_mismatch("frame byte with nothing pending", 32'(rsp_payload.frame_byte),
                            32'd0);
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_payload.frame_byte !== want.frame_byte) begin
               report_mismatch("frame_byte", 32'(rsp_payload.frame_byte),
                               32'(want.frame_byte));
            end
            if (rsp_payload.byte_position !== want.byte_position) begin
               report_mismatch("byte_position", 32'(rsp_payload.byte_position),
                               32'(want.byte_position));
            end
            if (rsp_payload.frame_last !== want.frame_last) begin
               report_mismatch("frame_last", 32'(rsp_payload.frame_last),
                               32'(want.frame_last));
            end
         end
         result_beats++;
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("wheel_command_frame_builder verification failed");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      read_register(CSR_IDX_GROUP);
      read_register(CSR_IDX_ROBOT);

      queue_command(make_command(16'h0000, 16'h0000, MODE_OFF, CMD_WHEELS, '0, '0, '0));
      queue_command(make_command(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, '1, '1, '1));
      queue_command(make_command(16'h8000, 16'h7FFF, MODE_ON, CMD_WHEELS, '0, '0, '0));
      queue_command(make_command(16'h7FFF, 16'h8000, MODE_ON, CMD_LED, 32'h1, 32'h2, 32'h3));
      queue_command(make_command(16'h0100, 16'hFF00, MODE_ODO_PRESET, CMD_WHEELS_ODOMETRY,
                                 32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0001));
      queue_command(make_command(16'h0080, 16'hFF80, 16'd7, 8'h00,
                                 32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFE));
      queue_command(make_command(16'h1234, 16'hEDCC, MODE_OFF, CMD_WHEELS_ODOMETRY,
                                 32'hFFFF_FFFF, 32'h0000_0000, 32'h3F80_0000));
      wait_until_drained();

      set_identifiers(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_command(make_command(16'h0000, 16'h0000, MODE_OFF, CMD_WHEELS, '0, '0, '0));
      queue_command(make_command(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, '1, '1, '1));
      queue_command(make_command(16'h8000, 16'h7FFF, MODE_ODO_PRESET, CMD_WHEELS_ODOMETRY,
                                 32'hDEAD_BEEF, 32'h0BAD_F00D, 32'hC0FF_EE00));
      queue_command(make_command(16'h0001, 16'hFFFE, MODE_ON, CMD_LED, '0, '1, '0));
      wait_until_drained();

      set_identifiers(32'h0000_0001, 32'h0000_8000);
      queue_command(make_command(16'h7FFF, 16'h7FFF, MODE_ON, CMD_WHEELS, '1, '0, '1));
      queue_command(make_command(16'h8000, 16'h8000, MODE_OFF, 8'h80, '0, '1, '0));
      wait_until_drained();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: set_identifiers(32'h0000_0000, 32'h0000_0000);
            1: set_identifiers(32'h0000_00FF, 32'h0000_FFFF);
            default: set_identifiers($urandom, $urandom);
         endcase
         idling_on = (phase != 2);
         for (int n = 0; n < COMMANDS_PER_PHASE; n++) begin
            queue_command(random_command());
         end
         wait_until_drained();
      end
      idling_on = 1'b1;

      repeat (8) @(posedge clock);
      if (expected_bytes.size() != 0) begin
         report_mismatch("frame bytes never delivered", 32'(expected_bytes.size()), 32'd0);
      end
      if (mismatch_count == 0) begin
         $display("wheel_command_frame_builder verification clean");
      end else begin
         $display("wheel_command_frame_builder verification failed");
      end
      $finish;
   end

endmodule
